@@ src/cflg_pkg.sv @@
package cflg_pkg;

  typedef enum logic [2:0] {
    RegLampsEnable      = 3'd0,
    RegGreenOnly        = 3'd1,
    RegRegenNotifyEn    = 3'd2,
    RegGongEnable       = 3'd3,
    RegBlinkIntervalMs  = 3'd4,
    RegInfoFrameId      = 3'd5,
    RegBrightFrameId    = 3'd6,
    RegDriveFrameId     = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    TxNone  = 2'd0,
    TxGong  = 2'd1,
    TxBlink = 2'd2
  } tx_kind_e;

  localparam int unsigned IdW      = 11;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [7:0] RegenMask  = 8'h21;
  localparam logic [7:0] BlinkBit   = 8'h02;
  localparam logic [7:0] GongBit    = 8'h01;
  localparam logic [7:0] CodeYellow = 8'h08;
  localparam logic [7:0] CodeGreen  = 8'h10;

  // brightness map: (raw - 27) * 186 / 73 + 69, saturated at 255
  localparam logic [7:0]  BrightOffset = 8'd27;
  localparam logic [7:0]  BrightBase   = 8'd69;
  localparam logic [7:0]  BrightSatRaw = 8'd100;
  localparam logic [7:0]  LevelMax     = 8'd255;
  localparam int unsigned RecipShift   = 20;
  // 186 * ceil(2^20 / 73), exact for products up to well beyond 72 * 186
  localparam logic [21:0] BrightRecip  = 22'd2671890;

  localparam logic [15:0] CfgIntervalRst = 16'd250;
  localparam logic [IdW-1:0] CfgInfoIdRst   = 11'd954;
  localparam logic [IdW-1:0] CfgBrightIdRst = 11'd1136;
  localparam logic [IdW-1:0] CfgDriveIdRst  = 11'd1152;

  typedef struct packed {
    logic           lamps_enable;
    logic           green_only;
    logic           regen_notify_enable;
    logic           gong_enable;
    logic [15:0]    blink_interval_ms;
    logic [IdW-1:0] info_frame_id;
    logic [IdW-1:0] brightness_frame_id;
    logic [IdW-1:0] drivetrain_frame_id;
  } cfg_t;

  typedef struct packed {
    logic             is_drive;
    logic             regen_active;
    logic             is_bright;
    logic             is_info;
    logic             code_yellow;
    logic             code_green;
    logic [7:0]       bright_level;
    logic [7:0][7:0]  data;
    logic [31:0]      time_ms;
  } cls_t;

  typedef struct packed {
    tx_kind_e         kind;
    logic [7:0][7:0]  tx;
    logic [7:0]       yellow;
    logic [7:0]       green;
  } res_t;

endpackage

@@ src/can_frame_led_gateway.sv @@
// lamp gateway for received can frames
// input side is a queue: present a frame on frame_id_i, data_byte_*_i and
// time_ms_i with push_i; it is taken at a clock edge where full_o is low.
// result side is a queue too: while empty_o is low the oldest result sits on
// tx_kind_o, tx_byte_*_o, yellow_level_o and green_level_o, and pop_i takes it.
// every frame yields exactly one result beat (tx_kind_o of none when nothing
// is sent, with all tx bytes zero).
// a frame is classified in the cycle it is pushed and lands in a small queue;
// the back end takes it from there, applies it to the state and writes the
// result queue, from which it can then be popped.
// throughput is one frame per cycle while the result queue is not full; the
// back end updates the state as it takes each frame.
// if the receiver stalls, the result queue fills, the back end holds, the
// middle queue fills and full_o rises; nothing is dropped.
// configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i;
// write it only while both queues are empty.
// reset (rst_ni low) empties both queues and returns all registers and state
// to their defaults.
module can_frame_led_gateway #(
  parameter int unsigned MidDepth = 2,
  parameter int unsigned OutDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cflg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cflg_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [cflg_pkg::IdW-1:0]      frame_id_i,
  input  logic [7:0]                    data_byte_0_i,
  input  logic [7:0]                    data_byte_1_i,
  input  logic [7:0]                    data_byte_2_i,
  input  logic [7:0]                    data_byte_3_i,
  input  logic [7:0]                    data_byte_4_i,
  input  logic [7:0]                    data_byte_5_i,
  input  logic [7:0]                    data_byte_6_i,
  input  logic [7:0]                    data_byte_7_i,
  input  logic [31:0]                   time_ms_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [1:0]                    tx_kind_o,
  output logic [7:0]                    tx_byte_0_o,
  output logic [7:0]                    tx_byte_1_o,
  output logic [7:0]                    tx_byte_2_o,
  output logic [7:0]                    tx_byte_3_o,
  output logic [7:0]                    tx_byte_4_o,
  output logic [7:0]                    tx_byte_5_o,
  output logic [7:0]                    tx_byte_6_o,
  output logic [7:0]                    tx_byte_7_o,
  output logic [7:0]                    yellow_level_o,
  output logic [7:0]                    green_level_o
);
  import cflg_pkg::*;

  cfg_t            cfg_q;
  logic [7:0][7:0] rx_data;
  cls_t            cls_in, cls_head;
  logic            mid_empty, mid_take;
  res_t            res_in, res_head;
  logic            res_full, res_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lamps_enable        <= 1'b1;
      cfg_q.green_only          <= 1'b1;
      cfg_q.regen_notify_enable <= 1'b1;
      cfg_q.gong_enable         <= 1'b1;
      cfg_q.blink_interval_ms   <= CfgIntervalRst;
      cfg_q.info_frame_id       <= CfgInfoIdRst;
      cfg_q.brightness_frame_id <= CfgBrightIdRst;
      cfg_q.drivetrain_frame_id <= CfgDriveIdRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegLampsEnable:     cfg_q.lamps_enable        <= cfg_wdata_i[0];
        RegGreenOnly:       cfg_q.green_only          <= cfg_wdata_i[0];
        RegRegenNotifyEn:   cfg_q.regen_notify_enable <= cfg_wdata_i[0];
        RegGongEnable:      cfg_q.gong_enable         <= cfg_wdata_i[0];
        RegBlinkIntervalMs: cfg_q.blink_interval_ms   <= cfg_wdata_i;
        RegInfoFrameId:     cfg_q.info_frame_id       <= cfg_wdata_i[IdW-1:0];
        RegBrightFrameId:   cfg_q.brightness_frame_id <= cfg_wdata_i[IdW-1:0];
        RegDriveFrameId:    cfg_q.drivetrain_frame_id <= cfg_wdata_i[IdW-1:0];
        default: ;
      endcase
    end
  end

  assign rx_data = {data_byte_7_i, data_byte_6_i, data_byte_5_i, data_byte_4_i,
                    data_byte_3_i, data_byte_2_i, data_byte_1_i, data_byte_0_i};

  cflg_front u_front (
    .cfg_i      (cfg_q),
    .frame_id_i (frame_id_i),
    .data_i     (rx_data),
    .time_ms_i  (time_ms_i),
    .cls_o      (cls_in)
  );

  cflg_fifo #(
    .Width ($bits(cls_t)),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cls_in),
    .full_o  (full_o),
    .pop_i   (mid_take),
    .rdata_o (cls_head),
    .empty_o (mid_empty)
  );

  cflg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cls_valid_i (!mid_empty),
    .cls_i       (cls_head),
    .cls_take_o  (mid_take),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  cflg_fifo #(
    .Width ($bits(res_t)),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .rdata_o (res_head),
    .empty_o (empty_o)
  );

  assign tx_kind_o      = res_head.kind;
  assign tx_byte_0_o    = res_head.tx[0];
  assign tx_byte_1_o    = res_head.tx[1];
  assign tx_byte_2_o    = res_head.tx[2];
  assign tx_byte_3_o    = res_head.tx[3];
  assign tx_byte_4_o    = res_head.tx[4];
  assign tx_byte_5_o    = res_head.tx[5];
  assign tx_byte_6_o    = res_head.tx[6];
  assign tx_byte_7_o    = res_head.tx[7];
  assign yellow_level_o = res_head.yellow;
  assign green_level_o  = res_head.green;

endmodule

@@ src/cflg_fifo.sv @@
module cflg_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ src/cflg_front.sv @@
module cflg_front (
  input  cflg_pkg::cfg_t             cfg_i,
  input  logic [cflg_pkg::IdW-1:0]   frame_id_i,
  input  logic [7:0][7:0]            data_i,
  input  logic [31:0]                time_ms_i,
  output cflg_pkg::cls_t             cls_o
);
  import cflg_pkg::*;

  logic [7:0]  raw;
  logic        above, below;
  logic [6:0]  span;
  logic [28:0] prod;
  logic [7:0]  quot;
  logic        bright_hit;

  assign raw   = data_i[4];
  assign above = (raw >= BrightSatRaw);
  assign below = (raw < BrightOffset);
  // distance from the knee, both sides share one constant multiplier
  assign span  = below ? 7'(BrightOffset - raw) : 7'(raw - BrightOffset);
  assign prod  = 29'(span) * 29'(BrightRecip);
  assign quot  = prod[RecipShift +: 8];

  assign bright_hit = (frame_id_i == cfg_i.brightness_frame_id);

  always_comb begin
    cls_o.is_drive     = cfg_i.regen_notify_enable && (frame_id_i == cfg_i.drivetrain_frame_id);
    cls_o.regen_active = ((data_i[0] & RegenMask) == RegenMask);
    cls_o.is_bright    = cfg_i.lamps_enable && bright_hit;
    cls_o.is_info      = cfg_i.lamps_enable && !bright_hit
                         && (frame_id_i == cfg_i.info_frame_id);
    cls_o.code_yellow  = (data_i[2] == CodeYellow);
    cls_o.code_green   = (data_i[2] == CodeGreen);
    priority if (above) begin
      cls_o.bright_level = LevelMax;
    end else if (below) begin
      cls_o.bright_level = BrightBase - quot;
    end else begin
      cls_o.bright_level = BrightBase + quot;
    end
    cls_o.data    = data_i;
    cls_o.time_ms = time_ms_i;
  end

endmodule

@@ src/cflg_back.sv @@
module cflg_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cflg_pkg::cfg_t  cfg_i,
  input  logic            cls_valid_i,
  input  cflg_pkg::cls_t  cls_i,
  output logic            cls_take_o,
  input  logic            res_full_i,
  output logic            res_push_o,
  output cflg_pkg::res_t  res_o
);
  import cflg_pkg::*;

  logic [7:0][7:0] info_q, info_d;
  logic [7:0][7:0] drv_q, drv_d;
  logic            was_q, was_d;
  logic            blink_q, blink_d;
  logic [31:0]     start_q, start_d;
  logic [7:0]      bright_q, bright_d;
  logic [7:0]      yellow_q, yellow_d;
  logic [7:0]      green_q, green_d;

  logic            fire;
  logic [15:0]     interval;
  logic [31:0]     elapsed;
  logic [7:0][7:0] gong_frame;
  logic [7:0][7:0] blink_frame;

  assign fire       = cls_valid_i && !res_full_i;
  assign cls_take_o = fire;
  assign res_push_o = fire;

  assign interval = (cfg_i.blink_interval_ms == '0) ? 16'd1 : cfg_i.blink_interval_ms;
  assign elapsed  = cls_i.time_ms - start_q;

  always_comb begin
    gong_frame    = info_q;
    gong_frame[2] = info_q[2] | GongBit;
    // blink frame is built on this frame's data, it replaced the stored one
    blink_frame    = cls_i.data;
    blink_frame[5] = blink_q ? (cls_i.data[5] & ~BlinkBit) : (cls_i.data[5] | BlinkBit);
    blink_frame[7] = blink_frame[1] ^ blink_frame[2] ^ blink_frame[3] ^ blink_frame[4]
                     ^ blink_frame[5] ^ blink_frame[6] ^ cls_i.data[7];
  end

  always_comb begin
    info_d   = info_q;
    drv_d    = drv_q;
    was_d    = was_q;
    blink_d  = blink_q;
    start_d  = start_q;
    bright_d = bright_q;
    yellow_d = yellow_q;
    green_d  = green_q;
    res_o.kind = TxNone;
    res_o.tx   = '0;

    if (cls_i.is_drive) begin
      if (cls_i.regen_active) begin
        drv_d = cls_i.data;
      end
      priority if (cls_i.regen_active && !was_q) begin
        start_d = cls_i.time_ms;
        blink_d = 1'b0;
        was_d   = 1'b1;
        if (cfg_i.gong_enable) begin
          res_o.kind = TxGong;
          res_o.tx   = gong_frame;
        end
      end else if (!cls_i.regen_active && was_q) begin
        was_d = 1'b0;
        if (cfg_i.gong_enable) begin
          res_o.kind = TxGong;
          res_o.tx   = gong_frame;
        end
      end else if (cls_i.regen_active) begin
        if (elapsed >= {16'd0, interval}) begin
          start_d    = cls_i.time_ms;
          blink_d    = !blink_q;
          drv_d      = blink_frame;
          res_o.kind = TxBlink;
          res_o.tx   = blink_frame;
        end
      end else begin
        // regen idle, nothing to send
      end
    end

    if (cls_i.is_bright) begin
      bright_d = cls_i.bright_level;
    end else if (cls_i.is_info) begin
      priority if (cls_i.code_yellow && !cfg_i.green_only) begin
        yellow_d = bright_q;
        green_d  = '0;
      end else if (cls_i.code_green) begin
        yellow_d = '0;
        green_d  = bright_q;
      end else begin
        if (!cfg_i.green_only) begin
          yellow_d = '0;
        end
        green_d = '0;
      end
      info_d = cls_i.data;
    end

    res_o.yellow = yellow_d;
    res_o.green  = green_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      info_q   <= '0;
      drv_q    <= '0;
      was_q    <= 1'b0;
      blink_q  <= 1'b0;
      start_q  <= '0;
      bright_q <= LevelMax;
      yellow_q <= '0;
      green_q  <= '0;
    end else if (fire) begin
      info_q   <= info_d;
      drv_q    <= drv_d;
      was_q    <= was_d;
      blink_q  <= blink_d;
      start_q  <= start_d;
      bright_q <= bright_d;
      yellow_q <= yellow_d;
      green_q  <= green_d;
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import cflg_pkg::*;

  localparam int unsigned IdlePct     = 26;
  localparam int unsigned PerPhase    = 315;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReports  = 50;
  localparam int          BrightNum   = 186;
  localparam int          BrightDen   = 73;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [7:0][7:0] data;
    logic [31:0]     time_ms;
  } rx_frame_t;

  // keeps its own copy of registers and lamp/regen state, queues the tx beat
  // each accepted frame should produce
  class tx_tracker;
    logic            lamps_en, green_only, regen_en, gong_en;
    logic [15:0]     blink_ivl;
    logic [IdW-1:0]  info_id, bright_id, drive_id;
    logic [7:0][7:0] info_frame, drive_frame;
    logic            regen_was, blink_on;
    logic [31:0]     blink_start;
    logic [7:0]      brightness, yellow, green;
    res_t            tx_due[$];
    int unsigned     errors;

    function new();
      lamps_en    = 1'b1;
      green_only  = 1'b1;
      regen_en    = 1'b1;
      gong_en     = 1'b1;
      blink_ivl   = CfgIntervalRst;
      info_id     = CfgInfoIdRst;
      bright_id   = CfgBrightIdRst;
      drive_id    = CfgDriveIdRst;
      info_frame  = '0;
      drive_frame = '0;
      regen_was   = 1'b0;
      blink_on    = 1'b0;
      blink_start = '0;
      brightness  = LevelMax;
      yellow      = '0;
      green       = '0;
      errors      = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        RegLampsEnable:     lamps_en = val[0];
        RegGreenOnly:       green_only = val[0];
        RegRegenNotifyEn:   regen_en = val[0];
        RegGongEnable:      gong_en = val[0];
        RegBlinkIntervalMs: blink_ivl = val;
        RegInfoFrameId:     info_id = val[IdW-1:0];
        RegBrightFrameId:   bright_id = val[IdW-1:0];
        RegDriveFrameId:    drive_id = val[IdW-1:0];
        default: ;
      endcase
    endfunction

    function void note_frame(rx_frame_t f);
      res_t        r;
      logic        active;
      logic [31:0] ivl;
      logic [7:0]  x;
      int          lvl;
      int          i;
      r = '0;
      // drivetrain handling goes first, so a gong sees the old info frame
      if (regen_en && f.id == drive_id) begin
        active = (f.data[0] & RegenMask) == RegenMask;
        ivl = (blink_ivl == '0) ? 32'd1 : 32'(blink_ivl);
        if (active) drive_frame = f.data;
        if (active && !regen_was) begin
          blink_start = f.time_ms;
          blink_on    = 1'b0;
          regen_was   = 1'b1;
          if (gong_en) begin
            r.kind  = TxGong;
            r.tx    = info_frame;
            r.tx[2] = r.tx[2] | GongBit;
          end
        end else if (!active && regen_was) begin
          regen_was = 1'b0;
          if (gong_en) begin
            r.kind  = TxGong;
            r.tx    = info_frame;
            r.tx[2] = r.tx[2] | GongBit;
          end
        end else if (active && (f.time_ms - blink_start) >= ivl) begin
          blink_start = f.time_ms;
          blink_on    = !blink_on;
          drive_frame[5] = blink_on ? (drive_frame[5] | BlinkBit) : (drive_frame[5] & ~BlinkBit);
          // old byte 7 takes part in its own checksum
          x = '0;
          for (i = 1; i < 8; i++) x = x ^ drive_frame[i];
          drive_frame[7] = x;
          r.kind = TxBlink;
          r.tx   = drive_frame;
        end
      end
      if (lamps_en && f.id == bright_id) begin
        lvl = (int'(f.data[4]) - int'(BrightOffset)) * BrightNum / BrightDen + int'(BrightBase);
        brightness = (lvl > 255) ? LevelMax : (lvl < 0) ? 8'd0 : 8'(lvl);
      end else if (lamps_en && f.id == info_id) begin
        if (f.data[2] == CodeYellow && !green_only) begin
          yellow = brightness;
          green  = '0;
        end else if (f.data[2] == CodeGreen) begin
          yellow = '0;
          green  = brightness;
        end else begin
          if (!green_only) yellow = '0;
          green = '0;
        end
        info_frame = f.data;
      end
      r.yellow = yellow;
      r.green  = green;
      tx_due.push_back(r);
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    endfunction

    function void check_tx(res_t got);
      res_t want;
      int   i;
      if (tx_due.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: result beat with nothing expected, expected none, got kind %0d",
                   $time, got.kind);
        return;
      end
      want = tx_due.pop_front();
      if (got.kind !== want.kind) flag("tx_kind", 32'(want.kind), 32'(got.kind));
      for (i = 0; i < 8; i++)
        if (got.tx[i] !== want.tx[i])
          flag($sformatf("tx_byte_%0d", i), 32'(want.tx[i]), 32'(got.tx[i]));
      if (got.yellow !== want.yellow) flag("yellow_level", 32'(want.yellow), 32'(got.yellow));
      if (got.green !== want.green) flag("green_level", 32'(want.green), 32'(got.green));
    endfunction
  endclass

  logic                clk;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                push_i;
  logic                full_o;
  logic [IdW-1:0]      frame_id_i;
  logic [7:0]          data_byte_0_i, data_byte_1_i, data_byte_2_i, data_byte_3_i;
  logic [7:0]          data_byte_4_i, data_byte_5_i, data_byte_6_i, data_byte_7_i;
  logic [31:0]         time_ms_i;
  logic                empty_o;
  logic                pop_i;
  logic [1:0]          tx_kind_o;
  logic [7:0]          tx_byte_0_o, tx_byte_1_o, tx_byte_2_o, tx_byte_3_o;
  logic [7:0]          tx_byte_4_o, tx_byte_5_o, tx_byte_6_o, tx_byte_7_o;
  logic [7:0]          yellow_level_o, green_level_o;

  tx_tracker   sb;
  logic        calm;
  logic [31:0] clock_ms;
  int unsigned stall_cycles;

  can_frame_led_gateway u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push_i         (push_i),
    .full_o         (full_o),
    .frame_id_i     (frame_id_i),
    .data_byte_0_i  (data_byte_0_i),
    .data_byte_1_i  (data_byte_1_i),
    .data_byte_2_i  (data_byte_2_i),
    .data_byte_3_i  (data_byte_3_i),
    .data_byte_4_i  (data_byte_4_i),
    .data_byte_5_i  (data_byte_5_i),
    .data_byte_6_i  (data_byte_6_i),
    .data_byte_7_i  (data_byte_7_i),
    .time_ms_i      (time_ms_i),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .tx_kind_o      (tx_kind_o),
    .tx_byte_0_o    (tx_byte_0_o),
    .tx_byte_1_o    (tx_byte_1_o),
    .tx_byte_2_o    (tx_byte_2_o),
    .tx_byte_3_o    (tx_byte_3_o),
    .tx_byte_4_o    (tx_byte_4_o),
    .tx_byte_5_o    (tx_byte_5_o),
    .tx_byte_6_o    (tx_byte_6_o),
    .tx_byte_7_o    (tx_byte_7_o),
    .yellow_level_o (yellow_level_o),
    .green_level_o  (green_level_o)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic rx_frame_t mk(logic [IdW-1:0] id, logic [63:0] data, logic [31:0] t);
    rx_frame_t f;
    f.id      = id;
    f.data    = data;
    f.time_ms = t;
    return f;
  endfunction

  // mostly frames on the configured ids with a clock that advances around the
  // blink interval; a few time jumps and stray ids
  function automatic rx_frame_t random_frame();
    rx_frame_t   f;
    int unsigned pick;
    int unsigned ivl;
    ivl  = (sb.blink_ivl == '0) ? 1 : int'(sb.blink_ivl);
    pick = $urandom_range(0, 99);
    if (pick < 3) clock_ms = $urandom;
    else if (pick < 15) clock_ms = clock_ms + $urandom_range(ivl, ivl + 3);
    else clock_ms = clock_ms + $urandom_range(0, ivl / 2 + 2);
    f.time_ms = clock_ms;
    f.data    = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      f.id = sb.drive_id;
      if (pick < 28) f.data[0] = f.data[0] | RegenMask;
      else if (pick < 34) f.data[0][$urandom_range(0, 1) ? 0 : 5] = 1'b0;
    end else if (pick < 55) begin
      f.id = sb.bright_id;
      if (pick < 50) f.data[4] = 8'($urandom_range(15, 110));
    end else if (pick < 75) begin
      f.id = sb.info_id;
      case ($urandom_range(0, 2))
        0: f.data[2] = CodeYellow;
        1: f.data[2] = CodeGreen;
        default: ;
      endcase
    end else begin
      f.id = IdW'($urandom_range(0, 2047));
    end
    return f;
  endfunction

  task automatic send_frame(input rx_frame_t f);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      push_i <= 1'b0;
      @(negedge clk);
    end
    push_i        <= 1'b1;
    frame_id_i    <= f.id;
    data_byte_0_i <= f.data[0];
    data_byte_1_i <= f.data[1];
    data_byte_2_i <= f.data[2];
    data_byte_3_i <= f.data[3];
    data_byte_4_i <= f.data[4];
    data_byte_5_i <= f.data[5];
    data_byte_6_i <= f.data[6];
    data_byte_7_i <= f.data[7];
    time_ms_i     <= f.time_ms;
    do @(posedge clk); while (full_o);
    sb.note_frame(f);
  endtask

  task automatic run_random(input int unsigned count);
    rx_frame_t   f;
    int unsigned n;
    n = 0;
    while (n < count) begin
      f = random_frame();
      n++;
      send_frame(f);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    push_i <= 1'b0;
    while (sb.tx_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] lamps, input logic [15:0] grn_only,
                              input logic [15:0] regen, input logic [15:0] gong,
                              input logic [15:0] ivl, input logic [15:0] info,
                              input logic [15:0] bright, input logic [15:0] drive);
    logic [CfgDataW-1:0] v [8];
    reg_idx_e            idx;
    v[RegLampsEnable]     = lamps;
    v[RegGreenOnly]       = grn_only;
    v[RegRegenNotifyEn]   = regen;
    v[RegGongEnable]      = gong;
    v[RegBlinkIntervalMs] = ivl;
    v[RegInfoFrameId]     = info;
    v[RegBrightFrameId]   = bright;
    v[RegDriveFrameId]    = drive;
    idx = idx.first();
    do begin
      @(negedge clk);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= v[idx];
      @(posedge clk);
      sb.set_reg(idx, v[idx]);
      idx = idx.next();
    end while (idx != idx.first());
    @(negedge clk);
    cfg_we_i <= 1'b0;
  endtask

  // result side: random stalls, none while calm
  initial begin
    pop_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk);
      pop_i <= calm || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  always @(posedge clk) begin
    res_t seen;
    if (rst_ni && pop_i && !empty_o) begin
      seen.kind   = tx_kind_e'(tx_kind_o);
      seen.tx     = {tx_byte_7_o, tx_byte_6_o, tx_byte_5_o, tx_byte_4_o,
                     tx_byte_3_o, tx_byte_2_o, tx_byte_1_o, tx_byte_0_o};
      seen.yellow = yellow_level_o;
      seen.green  = green_level_o;
      sb.check_tx(seen);
    end
  end

  always @(posedge clk) begin
    if (!rst_ni || (push_i && !full_o) || (pop_i && !empty_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegLampsEnable;
    cfg_wdata_i   = '0;
    push_i        = 1'b0;
    frame_id_i    = '0;
    data_byte_0_i = '0;
    data_byte_1_i = '0;
    data_byte_2_i = '0;
    data_byte_3_i = '0;
    data_byte_4_i = '0;
    data_byte_5_i = '0;
    data_byte_6_i = '0;
    data_byte_7_i = '0;
    time_ms_i     = '0;
    calm          = 1'b0;
    clock_ms      = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // ramp ends and saturation
    send_frame(mk(CfgBrightIdRst, 64'h0000_0000_0000_0000, 32'd0));
    send_frame(mk(CfgInfoIdRst, 64'h0000_0000_0010_0000, 32'd0));
    send_frame(mk(CfgBrightIdRst, 64'h0000_00FF_0000_0000, 32'd0));
    send_frame(mk(CfgBrightIdRst, 64'h0000_0064_0000_0000, 32'd0));
    send_frame(mk(CfgBrightIdRst, 64'h0000_0063_0000_0000, 32'd0));
    // yellow code ignored while green only, then green
    send_frame(mk(CfgInfoIdRst, 64'h1122_3344_5508_6677, 32'd0));
    send_frame(mk(CfgInfoIdRst, 64'hA5A5_A5A5_A510_A5A5, 32'd0));
    // regen start gong, blink on at exactly one interval, blink off
    send_frame(mk(CfgDriveIdRst, 64'h0000_0000_0000_0021, 32'd1000));
    send_frame(mk(CfgDriveIdRst, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1249));
    send_frame(mk(CfgDriveIdRst, 64'h0102_0304_0506_07A1, 32'd1250));
    send_frame(mk(CfgDriveIdRst, 64'h0102_0304_0506_07A1, 32'd1499));
    send_frame(mk(CfgDriveIdRst, 64'h0102_0304_0506_07A1, 32'd1500));
    send_frame(mk(CfgInfoIdRst, 64'h0000_0000_00FF_0000, 32'd0));
    // regen end gong, then an inactive frame with regen idle
    send_frame(mk(CfgDriveIdRst, 64'h0000_0000_0000_0020, 32'd1600));
    send_frame(mk(CfgDriveIdRst, 64'h0000_0000_0000_0001, 32'd1700));
    // blink across the millisecond clock wrap
    send_frame(mk(CfgDriveIdRst, 64'h0000_0000_0000_0021, 32'hFFFF_FF00));
    send_frame(mk(CfgDriveIdRst, 64'h8040_2010_0804_023F, 32'h0000_00FA));
    send_frame(mk(CfgDriveIdRst, 64'h0000_0000_0000_00DE, 32'h0000_0100));
    // stray ids
    send_frame(mk(11'h000, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    send_frame(mk(11'h7FF, 64'h0000_0000_0000_0000, 32'd0));
    run_random(PerPhase);
    drain();

    // shortest interval, yellow allowed
    program_regs(16'd1, 16'd0, 16'd1, 16'd1, 16'd1, 16'(CfgInfoIdRst),
                 16'(CfgBrightIdRst), 16'(CfgDriveIdRst));
    run_random(PerPhase);
    drain();

    // longest interval, lamps and gong off, no stalls on either side
    program_regs(16'd0, 16'd1, 16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd2047,
                 16'(CfgDriveIdRst));
    calm = 1'b1;
    run_random(PerPhase);
    drain();
    calm = 1'b0;

    // zero interval, drivetrain and info frames share an id
    program_regs(16'd1, 16'd0, 16'd1, 16'd1, 16'd0, 16'h0123, 16'h07FF, 16'h0123);
    run_random(PerPhase);
    drain();

    // all three ids equal: brightness wins over info
    program_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd40, 16'd0, 16'd0, 16'd0);
    run_random(PerPhase);
    drain();

    // wide values masked to register widths, regen tracking off
    program_regs(16'hFFFF, 16'hFFFE, 16'hFFFE, 16'h8001, 16'd100, 16'hFBBA,
                 16'hFC70, 16'hFC80);
    run_random(PerPhase);
    drain();

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
